// ===== hdl/edca_pkg.sv =====
// Shared types, constants and codes for the EDCA channel access backoff block.
// No dependencies; every other file imports this package.
`default_nettype none

package edca_pkg;

    // Field widths
    localparam int WINDOW_BITS   = 10;
    localparam int TIME_BITS     = 10;
    localparam int RETRY_BITS    = 4;
    localparam int SLOT_BITS     = 8;
    // slot remainder plus leftover elapsed time
    localparam int ACC_BITS      = TIME_BITS + 1;
    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 10;

    typedef logic [WINDOW_BITS-1:0] t_window;
    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [RETRY_BITS-1:0]  t_retry;
    typedef logic [SLOT_BITS-1:0]   t_slot;
    typedef logic [ACC_BITS-1:0]    t_acc;
    typedef logic [OP_BITS-1:0]     t_opcode;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    // Event codes
    localparam t_opcode OP_TICK    = 2'd0;
    localparam t_opcode OP_ENQUEUE = 2'd1;
    localparam t_opcode OP_TX_OK   = 2'd2;
    localparam t_opcode OP_TX_FAIL = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_CW_MIN      = 3'd0;
    localparam t_cfg_idx CFG_CW_MAX      = 3'd1;
    localparam t_cfg_idx CFG_RETRY_LIMIT = 3'd2;
    localparam t_cfg_idx CFG_AIFS_TIME   = 3'd3;
    localparam t_cfg_idx CFG_SLOT_TIME   = 3'd4;

    // Register reset values
    localparam t_window RST_CW_MIN      = 10'd15;
    localparam t_window RST_CW_MAX      = 10'd1023;
    localparam t_retry  RST_RETRY_LIMIT = 4'd7;
    localparam t_time   RST_AIFS_TIME   = 10'd264;
    localparam t_slot   RST_SLOT_TIME   = 8'd52;

    typedef struct packed {
        t_window cw_min;
        t_window cw_max;
        t_retry  retry_limit;
        t_time   aifs_time;
        t_slot   slot_time;
    } t_cfg;

    // Result of the serial divider
    typedef struct packed {
        logic  done;
        t_acc  quot;
        t_slot rem;
    } t_div_res;

endpackage

`default_nettype wire

// ===== hdl/edca_if.sv =====
// Valid/ready channel interfaces: input events, results and register writes.
// Depends on edca_pkg for payload types.
`default_nettype none

interface edca_in_if;
    import edca_pkg::*;
    logic     valid;
    logic     ready;
    t_opcode  opcode;
    t_time    elapsed_time;
    logic     medium_busy;
    logic     gate_open;
    logic     queue_nonempty;
    t_window  random_draw;

    modport source (output valid, opcode, elapsed_time, medium_busy, gate_open,
                    queue_nonempty, random_draw, input ready);
    modport sink   (input valid, opcode, elapsed_time, medium_busy, gate_open,
                    queue_nonempty, random_draw, output ready);
endinterface

interface edca_out_if;
    import edca_pkg::*;
    logic    valid;
    logic    ready;
    logic    expired;
    logic    dropped;
    logic    contending;
    t_window window_now;
    t_retry  retries_now;
    t_window slots_left;
    t_time   aifs_left;

    modport source (output valid, expired, dropped, contending, window_now,
                    retries_now, slots_left, aifs_left, input ready);
    modport sink   (input valid, expired, dropped, contending, window_now,
                    retries_now, slots_left, aifs_left, output ready);
endinterface

interface edca_cfg_if;
    import edca_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/edca_cfg.sv =====
// Configuration register bank: cw_min, cw_max, retry limit, AIFS and slot time.
// Depends on edca_pkg and edca_cfg_if.
`default_nettype none

module edca_cfg (
    input  wire          i_clk,
    input  wire          i_rst_n,
    edca_cfg_if.sink     i_cfg,
    output edca_pkg::t_cfg o_cfg
);
    import edca_pkg::*;

    t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cw_min      <= RST_CW_MIN;
            r_cfg.cw_max      <= RST_CW_MAX;
            r_cfg.retry_limit <= RST_RETRY_LIMIT;
            r_cfg.aifs_time   <= RST_AIFS_TIME;
            r_cfg.slot_time   <= RST_SLOT_TIME;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CW_MIN:      r_cfg.cw_min      <= i_cfg.data[WINDOW_BITS-1:0];
                CFG_CW_MAX:      r_cfg.cw_max      <= i_cfg.data[WINDOW_BITS-1:0];
                CFG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg.data[RETRY_BITS-1:0];
                CFG_AIFS_TIME:   r_cfg.aifs_time   <= i_cfg.data[TIME_BITS-1:0];
                CFG_SLOT_TIME:   r_cfg.slot_time   <= i_cfg.data[SLOT_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/edca_div.sv =====
// Restoring bit-serial divider: idle microseconds by slot time, one quotient
// bit per cycle. Depends on edca_pkg.
`default_nettype none

module edca_div (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  edca_pkg::t_acc  i_dividend,
    input  edca_pkg::t_slot i_divisor,
    output edca_pkg::t_div_res o_res
);
    import edca_pkg::*;

    localparam int CNT_BITS = $clog2(ACC_BITS + 1);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(ACC_BITS - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    t_acc                r_quot;
    logic [SLOT_BITS:0]  r_part;
    t_slot               r_div;

    logic [SLOT_BITS:0]  w_shift;
    logic                w_ge;

    // one trial subtraction per cycle
    assign w_shift = {r_part[SLOT_BITS-1:0], r_quot[ACC_BITS-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_part <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_part <= w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
            r_quot <= {r_quot[ACC_BITS-2:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_part[SLOT_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/edca_channel_access_backoff.sv =====
// Top level of the EDCA channel access backoff: sequencer, contention state
// and result register. Depends on edca_pkg, edca_if, edca_cfg and edca_div.
//
// One item is taken at a time. Every item passes through latch, update and
// result load; an idle tick that reaches the backoff phase also runs the
// bit-serial divider between update and result load, which turns the idle
// microseconds into whole slots and a remainder at one quotient bit per
// cycle. A finished result sits in an output register, so the next item is
// taken while it waits; a later result waits in turn until that register is
// free. Register writes are taken at any time, one per cycle.
`default_nettype none

module edca_channel_access_backoff (
    input  wire         i_clk,
    input  wire         i_rst_n,
    edca_in_if.sink     i_item,
    edca_out_if.source  o_result,
    edca_cfg_if.sink    i_cfg
);
    import edca_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    t_cfg     w_cfg;
    t_div_res w_div;

    logic [1:0] r_state, n_state;

    // latched item
    t_opcode r_op;
    t_time   r_elapsed;
    logic    r_busy_med, r_gate, r_queued;
    t_window r_draw;

    // contention state
    t_window r_window, n_window;
    t_retry  r_retry, n_retry;
    logic    r_active, n_active;
    t_time   r_aifs, n_aifs;
    t_window r_back, n_back;
    t_slot   r_rem, n_rem;
    logic    r_dropped, n_dropped;

    // result register
    logic    r_out_valid;
    logic    r_out_expired, r_out_dropped, r_out_contending;
    t_window r_out_window, r_out_slots;
    t_retry  r_out_retries;
    t_time   r_out_aifs;

    // update scratch
    logic                 w_start, w_adv, w_div_start;
    logic [WINDOW_BITS:0] w_grown;
    logic [RETRY_BITS:0]  w_next_retry;
    t_window              w_clamp;
    t_time                w_use, w_dt_rest, w_aifs_new;
    t_acc                 w_acc;
    t_slot                w_divisor;
    t_acc                 w_take;
    logic                 w_out_free;

    edca_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_divisor = (w_cfg.slot_time == '0) ? t_slot'(1) : w_cfg.slot_time;

    edca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_acc),
        .i_divisor  (w_divisor),
        .o_res      (w_div)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign w_out_free   = !r_out_valid || o_result.ready;

    // AIFS consumption for an idle tick
    always_comb begin
        w_use      = (r_elapsed < r_aifs) ? r_elapsed : r_aifs;
        w_aifs_new = r_aifs - w_use;
        w_dt_rest  = r_elapsed - w_use;
        w_acc      = ACC_BITS'(r_rem) + ACC_BITS'(w_dt_rest);
    end

    // event update, applied in S_EXEC
    always_comb begin
        n_window     = r_window;
        n_retry      = r_retry;
        n_active     = r_active;
        n_aifs       = r_aifs;
        n_back       = r_back;
        n_rem        = r_rem;
        n_dropped    = 1'b0;
        w_start      = 1'b0;
        w_adv        = 1'b0;
        w_grown      = {r_window, 1'b1};
        w_next_retry = {1'b0, r_retry} + 1'b1;

        unique case (r_op)
            OP_TICK: begin
                if (!r_queued) begin
                    n_window = w_cfg.cw_min;
                    n_retry  = '0;
                    n_active = 1'b0;
                    n_aifs   = '0;
                    n_back   = '0;
                    n_rem    = '0;
                end else if (!r_gate) begin
                    n_active = 1'b0;
                end else if (!r_active) begin
                    w_start = 1'b1;
                end else if (!r_busy_med) begin
                    w_adv  = 1'b1;
                    n_aifs = w_aifs_new;
                end
            end
            OP_ENQUEUE: begin
                if (!r_active && r_queued) begin
                    if (r_gate) begin
                        w_start = 1'b1;
                    end else begin
                        n_active = 1'b0;
                    end
                end
            end
            OP_TX_OK: begin
                n_window = w_cfg.cw_min;
                n_retry  = '0;
                n_active = 1'b0;
                if (!r_queued) begin
                    n_aifs = '0;
                    n_back = '0;
                    n_rem  = '0;
                end else if (r_gate) begin
                    w_start = 1'b1;
                end
            end
            OP_TX_FAIL: begin
                n_window = (w_grown < {1'b0, w_cfg.cw_max}) ?
                           w_grown[WINDOW_BITS-1:0] : w_cfg.cw_max;
                if (w_next_retry > {1'b0, w_cfg.retry_limit}) begin
                    n_dropped = 1'b1;
                    n_window  = w_cfg.cw_min;
                    n_retry   = '0;
                end else begin
                    n_retry = w_next_retry[RETRY_BITS-1:0];
                end
                n_active = 1'b0;
                w_start  = r_queued && r_gate;
            end
            default: ;
        endcase

        // fresh contention: clamp window, load AIFS, draw backoff
        w_clamp = (n_window < w_cfg.cw_max) ? n_window : w_cfg.cw_max;
        if (w_clamp < w_cfg.cw_min) begin
            w_clamp = w_cfg.cw_min;
        end
        if (w_start) begin
            n_window = w_clamp;
            n_active = 1'b1;
            n_aifs   = w_cfg.aifs_time;
            n_back   = r_draw & w_clamp;
            n_rem    = '0;
        end
    end

    assign w_div_start = (r_state == S_EXEC) && w_adv && (w_aifs_new == '0);
    assign w_take      = (w_div.quot < ACC_BITS'(r_back)) ? w_div.quot : ACC_BITS'(r_back);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_item.valid) n_state = S_EXEC;
            S_EXEC: n_state = w_div_start ? S_DIV : S_PUT;
            S_DIV:  if (w_div.done) n_state = S_PUT;
            S_PUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op       <= i_item.opcode;
            r_elapsed  <= i_item.elapsed_time;
            r_busy_med <= i_item.medium_busy;
            r_gate     <= i_item.gate_open;
            r_queued   <= i_item.queue_nonempty;
            r_draw     <= i_item.random_draw;
        end
    end

    // contention state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= RST_CW_MIN;
            r_retry   <= '0;
            r_active  <= 1'b0;
            r_aifs    <= '0;
            r_back    <= '0;
            r_rem     <= '0;
            r_dropped <= 1'b0;
        end else if (r_state == S_EXEC) begin
            r_window  <= n_window;
            r_retry   <= n_retry;
            r_active  <= n_active;
            r_aifs    <= n_aifs;
            r_back    <= n_back;
            r_rem     <= n_rem;
            r_dropped <= n_dropped;
        end else if (r_state == S_DIV && w_div.done) begin
            r_back <= r_back - w_take[WINDOW_BITS-1:0];
            r_rem  <= w_div.rem;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && w_out_free) begin
            r_out_expired    <= r_active && r_gate && !r_busy_med && r_queued &&
                                (r_aifs == '0) && (r_back == '0);
            r_out_dropped    <= r_dropped;
            r_out_contending <= r_active;
            r_out_window     <= r_window;
            r_out_retries    <= r_retry;
            r_out_slots      <= r_back;
            r_out_aifs       <= r_aifs;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.expired     = r_out_expired;
    assign o_result.dropped     = r_out_dropped;
    assign o_result.contending  = r_out_contending;
    assign o_result.window_now  = r_out_window;
    assign o_result.retries_now = r_out_retries;
    assign o_result.slots_left  = r_out_slots;
    assign o_result.aifs_left   = r_out_aifs;

endmodule

`default_nettype wire

// ===== hdl/edca_checker.sv =====
// Port-level checks for the EDCA backoff block, bound to the top level.
// Depends on edca_pkg and edca_channel_access_backoff.
`default_nettype none

module edca_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               i_in_ready,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire               i_expired,
    input wire               i_dropped,
    input wire               i_contending,
    input edca_pkg::t_retry  i_retries,
    input edca_pkg::t_window i_slots,
    input edca_pkg::t_time   i_aifs
);
    import edca_pkg::*;

    // a pending result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    // one item in flight: no input taken the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is still in work");

    // expiry only with contention active and both counts spent
    a_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_expired |->
            i_contending && (i_slots == '0) && (i_aifs == '0))
        else $error("expiry with contention not complete");

    // a dropped frame resets the retry count
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dropped |-> (i_retries == '0))
        else $error("drop without retry count reset");

endmodule

bind edca_channel_access_backoff edca_checker u_edca_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_expired    (o_result.expired),
    .i_dropped    (o_result.dropped),
    .i_contending (o_result.contending),
    .i_retries    (o_result.retries_now),
    .i_slots      (o_result.slots_left),
    .i_aifs       (o_result.aifs_left)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for edca_channel_access_backoff: directed event table
// then randomised contention traffic, checked against an in-bench backoff predictor.
// Depends on edca_pkg, the valid/ready interfaces in edca_if and edca_channel_access_backoff.
`timescale 1ns / 1ps

module tb_top;
    import edca_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 50;

    // Traffic pacing schemes
    typedef enum int {PACE_RX_STALLY, PACE_TX_GAPPY, PACE_FULL} t_pace;

    typedef struct packed {
        logic    expired;
        logic    dropped;
        logic    contending;
        t_window window_now;
        t_retry  retries_now;
        t_window slots_left;
        t_time   aifs_left;
    } t_status;

    typedef struct {
        bit        is_cfg;
        t_cfg_idx  reg_idx;
        t_cfg_data reg_val;
        t_opcode   op;
        t_time     elapsed;
        logic      busy;
        logic      gate;
        logic      queued;
        t_window   draw;
        bit        known;
        t_status   want;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    edca_in_if  item_ch ();
    edca_out_if status_ch ();
    edca_cfg_if reg_ch ();

    edca_channel_access_backoff dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (status_ch),
        .i_cfg    (reg_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Predictor copy of the registers and contention state
    t_window cf_cw_min, cf_cw_max;
    t_retry  cf_retry_limit;
    t_time   cf_aifs_time;
    t_slot   cf_slot_time;
    t_window st_window;
    t_retry  st_retries;
    logic    st_active;
    t_time   st_aifs;
    t_window st_backoff;
    t_slot   st_slot_rem;

    t_status   status_due[$];
    t_stim_row rows[$];
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      mismatches     = 0;
    int      n_events       = 0;
    int      n_directed     = 0;
    int      n_checked      = 0;
    int      n_drops        = 0;
    int      n_expiries     = 0;
    int      n_writes       = 0;
    bit      cur_known      = 1'b0;
    t_status cur_want       = '0;

    // Queue helpers
    function automatic void expect_status(t_status s);
        status_due = {status_due, s};
    endfunction

    function automatic void add_row(t_stim_row r);
        rows = {rows, r};
    endfunction

    //--------------------------------------------------------------------
    // Backoff predictor
    //--------------------------------------------------------------------
    function automatic void clear_contention();
        st_window   = cf_cw_min;
        st_retries  = '0;
        st_active   = 1'b0;
        st_aifs     = '0;
        st_backoff  = '0;
        st_slot_rem = '0;
    endfunction

    // Load a fresh contention unless the queue is empty, the gate is shut or one is already active
    function automatic void start_contention(logic queued, logic gate, t_window draw);
        t_window w;
        if (!queued)
            return;
        if (!gate) begin
            st_active = 1'b0;
            return;
        end
        if (!st_active) begin
            w = (st_window < cf_cw_max) ? st_window : cf_cw_max;
            if (w < cf_cw_min)
                w = cf_cw_min;
            st_window   = w;
            st_active   = 1'b1;
            st_aifs     = cf_aifs_time;
            st_backoff  = draw & w;
            st_slot_rem = '0;
        end
    endfunction

    // Idle time eats AIFS first, then whole slots; leftover us carried over
    function automatic void count_down(t_time dt);
        int unsigned left, spent, slot, acc, slots;
        left  = dt;
        spent = (left < st_aifs) ? left : st_aifs;
        st_aifs = t_time'(st_aifs - spent);
        left  = left - spent;
        if (st_aifs != 0)
            return;
        slot  = (cf_slot_time != 0) ? cf_slot_time : 1;
        acc   = st_slot_rem + left;
        slots = acc / slot;
        st_backoff  = t_window'(st_backoff - ((slots < st_backoff) ? slots : st_backoff));
        st_slot_rem = t_slot'(acc % slot);
    endfunction

    function automatic t_status step_backoff(t_opcode op, t_time elapsed, logic busy,
                                             logic gate, logic queued, t_window draw);
        t_status     s;
        int unsigned next_retry, grown;
        s = '0;
        case (op)
            OP_TICK: begin
                if (!queued)
                    clear_contention();
                else if (!gate)
                    st_active = 1'b0;
                else if (!st_active)
                    start_contention(queued, gate, draw);
                else if (!busy)
                    count_down(elapsed);
            end
            OP_ENQUEUE: begin
                if (!st_active)
                    start_contention(queued, gate, draw);
            end
            OP_TX_OK: begin
                st_window  = cf_cw_min;
                st_retries = '0;
                if (!queued) begin
                    clear_contention();
                end else begin
                    st_active = 1'b0;
                    start_contention(queued, gate, draw);
                end
            end
            default: begin
                next_retry = st_retries + 1;
                grown      = 2 * st_window + 1;
                st_window  = t_window'((grown < cf_cw_max) ? grown : cf_cw_max);
                if (next_retry > cf_retry_limit) begin
                    s.dropped  = 1'b1;
                    st_window  = cf_cw_min;
                    st_retries = '0;
                end else begin
                    st_retries = t_retry'(next_retry);
                end
                st_active = 1'b0;
                start_contention(queued, gate, draw);
            end
        endcase
        s.expired     = st_active && gate && !busy && queued && st_aifs == 0 &&
                        st_backoff == 0;
        s.contending  = st_active;
        s.window_now  = st_window;
        s.retries_now = st_retries;
        s.slots_left  = st_backoff;
        s.aifs_left   = st_aifs;
        return s;
    endfunction

    //--------------------------------------------------------------------
    // Monitor: result checks, register mirror, expectations on input transfer
    //--------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_status got, want;
        if (i_rst_n) begin
            if (status_ch.valid && status_ch.ready) begin
                got.expired     = status_ch.expired;
                got.dropped     = status_ch.dropped;
                got.contending  = status_ch.contending;
                got.window_now  = status_ch.window_now;
                got.retries_now = status_ch.retries_now;
                got.slots_left  = status_ch.slots_left;
                got.aifs_left   = status_ch.aifs_left;
                if (status_due.size() == 0) begin
                    $error("status transfer with no event outstanding");
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    n_checked++;
                    if (got.expired !== want.expired) begin
                        $error("expired: expected %0d, got %0d", want.expired, got.expired);
                        mismatches++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
                        mismatches++;
                    end
                    if (got.contending !== want.contending) begin
                        $error("contending: expected %0d, got %0d",
                               want.contending, got.contending);
                        mismatches++;
                    end
                    if (got.window_now !== want.window_now) begin
                        $error("window_now: expected %0d, got %0d",
                               want.window_now, got.window_now);
                        mismatches++;
                    end
                    if (got.retries_now !== want.retries_now) begin
                        $error("retries_now: expected %0d, got %0d",
                               want.retries_now, got.retries_now);
                        mismatches++;
                    end
                    if (got.slots_left !== want.slots_left) begin
                        $error("slots_left: expected %0d, got %0d",
                               want.slots_left, got.slots_left);
                        mismatches++;
                    end
                    if (got.aifs_left !== want.aifs_left) begin
                        $error("aifs_left: expected %0d, got %0d",
                               want.aifs_left, got.aifs_left);
                        mismatches++;
                    end
                end
            end
            // register writes only happen while idle, so ordering here is safe
            if (reg_ch.valid && reg_ch.ready) begin
                n_writes++;
                case (reg_ch.index)
                    CFG_CW_MIN:      cf_cw_min      = reg_ch.data;
                    CFG_CW_MAX:      cf_cw_max      = reg_ch.data;
                    CFG_RETRY_LIMIT: cf_retry_limit = reg_ch.data[RETRY_BITS-1:0];
                    CFG_AIFS_TIME:   cf_aifs_time   = reg_ch.data;
                    CFG_SLOT_TIME:   cf_slot_time   = reg_ch.data[SLOT_BITS-1:0];
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready) begin
                want = step_backoff(item_ch.opcode, item_ch.elapsed_time, item_ch.medium_busy,
                                    item_ch.gate_open, item_ch.queue_nonempty,
                                    item_ch.random_draw);
                n_events++;
                n_drops    += want.dropped;
                n_expiries += want.expired;
                expect_status(cur_known ? cur_want : want);
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk)
        status_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: ends the run if nothing moves on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (status_ch.valid && status_ch.ready) ||
                (reg_ch.valid && reg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, status_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    //--------------------------------------------------------------------
    // Drivers (called just after a falling edge, return just after one)
    //--------------------------------------------------------------------
    task automatic set_pace(t_pace pace);
        case (pace)
            PACE_RX_STALLY: begin send_idle_pct = 23; recv_stall_pct = 54; end
            PACE_TX_GAPPY:  begin send_idle_pct = 54; recv_stall_pct = 23; end
            default:        begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic send_item(input t_opcode op, input t_time elapsed, input logic busy,
                             input logic gate, input logic queued, input t_window draw,
                             input bit known, input t_status want);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.opcode         <= op;
        item_ch.elapsed_time   <= elapsed;
        item_ch.medium_busy    <= busy;
        item_ch.gate_open      <= gate;
        item_ch.queue_nonempty <= queued;
        item_ch.random_draw    <= draw;
        cur_known = known;
        cur_want  = want;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    // Drop the event valid and let every outstanding result come back
    task automatic wait_quiet();
        item_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input int cw_min, input int cw_max, input int retry_limit,
                                input int aifs, input int slot);
        wait_quiet();
        write_reg(CFG_CW_MIN, t_cfg_data'(cw_min));
        write_reg(CFG_CW_MAX, t_cfg_data'(cw_max));
        write_reg(CFG_RETRY_LIMIT, t_cfg_data'(retry_limit));
        write_reg(CFG_AIFS_TIME, t_cfg_data'(aifs));
        write_reg(CFG_SLOT_TIME, t_cfg_data'(slot));
        reg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed contention rounds; tx_pct pulls transmit outcomes in
    // early, fail_pct sets how many of them fail
    task automatic run_phase(input int n, input int tx_pct, input int fail_pct);
        t_opcode op;
        t_time   elapsed;
        logic    busy, gate, queued;
        t_window draw;
        int      slot_eff;
        for (int k = 0; k < n; k++) begin
            slot_eff = (cf_slot_time != 0) ? cf_slot_time : 1;
            if ($urandom_range(99) < 12) begin
                // noise: anything goes
                op      = t_opcode'($urandom_range(3));
                elapsed = t_time'($urandom_range(1023));
                busy    = ($urandom_range(1) == 1);
                gate    = ($urandom_range(1) == 1);
                queued  = ($urandom_range(1) == 1);
                draw    = t_window'($urandom_range(1023));
            end else begin
                busy    = ($urandom_range(99) < 20);
                gate    = ($urandom_range(99) < 93);
                queued  = ($urandom_range(99) < 96);
                draw    = t_window'($urandom_range(1023));
                elapsed = t_time'($urandom_range(1) ? $urandom_range(1023)
                                                    : $urandom_range(3 * slot_eff));
                if (!st_active)
                    op = $urandom_range(1) ? OP_ENQUEUE : OP_TICK;
                else if ((st_aifs == 0 && st_backoff == 0) || $urandom_range(99) < tx_pct)
                    op = ($urandom_range(99) < fail_pct) ? OP_TX_FAIL : OP_TX_OK;
                else
                    op = OP_TICK;
            end
            send_item(op, elapsed, busy, gate, queued, draw, 1'b0, '0);
        end
    endtask

    //--------------------------------------------------------------------
    // Directed table helpers
    //--------------------------------------------------------------------
    function automatic t_status st(bit ex, bit dr, bit co, int win, int ret, int sl, int af);
        return '{ex, dr, co, t_window'(win), t_retry'(ret), t_window'(sl), t_time'(af)};
    endfunction

    function automatic t_stim_row ev(t_opcode op, int elapsed, bit busy, bit gate,
                                     bit queued, int draw);
        t_stim_row r;
        r         = '{default: '0};
        r.op      = op;
        r.elapsed = t_time'(elapsed);
        r.busy    = busy;
        r.gate    = gate;
        r.queued  = queued;
        r.draw    = t_window'(draw);
        return r;
    endfunction

    function automatic t_stim_row ev_known(t_opcode op, int elapsed, bit busy, bit gate,
                                           bit queued, int draw, t_status want);
        t_stim_row r;
        r       = ev(op, elapsed, busy, gate, queued, draw);
        r.known = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_stim_row reg_row(t_cfg_idx idx, int val);
        t_stim_row r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = t_cfg_data'(val);
        return r;
    endfunction

    //--------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------
    initial begin : stimulus
        t_status   at_rest, fresh;

        item_ch.valid          = 1'b0;
        item_ch.opcode         = OP_TICK;
        item_ch.elapsed_time   = '0;
        item_ch.medium_busy    = 1'b0;
        item_ch.gate_open      = 1'b0;
        item_ch.queue_nonempty = 1'b0;
        item_ch.random_draw    = '0;
        reg_ch.valid           = 1'b0;
        reg_ch.index           = CFG_CW_MIN;
        reg_ch.data            = '0;

        cf_cw_min      = RST_CW_MIN;
        cf_cw_max      = RST_CW_MAX;
        cf_retry_limit = RST_RETRY_LIMIT;
        cf_aifs_time   = RST_AIFS_TIME;
        cf_slot_time   = RST_SLOT_TIME;
        clear_contention();
        set_pace(PACE_RX_STALLY);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every event type, empty queue, shut gate, frozen medium,
        // AIFS then slot countdown to expiry, window growth up to a drop,
        // then zero slot time and a minimum window above the maximum
        at_rest = st(0, 0, 0, 15, 0, 0, 0);
        fresh   = st(0, 0, 1, 15, 0, 15, 264);
        add_row(ev_known(OP_TICK, 0, 0, 1, 0, 0, at_rest));
        add_row(ev_known(OP_ENQUEUE, 1023, 1, 1, 0, 1023, at_rest));
        add_row(ev_known(OP_ENQUEUE, 0, 0, 0, 1, 1023, at_rest));
        add_row(ev_known(OP_ENQUEUE, 0, 0, 1, 1, 1023, fresh));
        add_row(ev_known(OP_ENQUEUE, 1023, 0, 1, 1, 0, fresh));
        add_row(ev_known(OP_TICK, 1023, 1, 1, 1, 0, fresh));
        add_row(ev_known(OP_TICK, 0, 0, 1, 1, 1023, fresh));
        add_row(ev(OP_TICK, 1023, 0, 1, 1, 0));
        add_row(ev(OP_TICK, 21, 0, 1, 1, 0));
        add_row(ev(OP_TX_FAIL, 0, 0, 1, 1, 1023));
        add_row(ev(OP_TX_FAIL, 0, 0, 0, 1, 1023));
        add_row(ev(OP_TICK, 500, 0, 0, 1, 0));
        add_row(ev(OP_TICK, 500, 0, 1, 1, 5));
        repeat (5) add_row(ev(OP_TX_FAIL, 0, 1, 1, 1, 682));
        add_row(ev_known(OP_TX_FAIL, 0, 0, 1, 1, 1023, st(0, 1, 1, 15, 0, 15, 264)));
        add_row(ev_known(OP_TX_OK, 0, 0, 1, 0, 0, at_rest));
        add_row(ev(OP_TX_OK, 0, 0, 1, 1, 7));
        add_row(reg_row(CFG_SLOT_TIME, 0));
        add_row(reg_row(CFG_AIFS_TIME, 0));
        add_row(reg_row(CFG_CW_MIN, 63));
        add_row(reg_row(CFG_CW_MAX, 7));
        add_row(ev_known(OP_TX_OK, 0, 0, 1, 1, 1023, st(0, 0, 1, 63, 0, 63, 0)));
        add_row(ev(OP_TICK, 40, 0, 1, 1, 0));
        add_row(ev(OP_TICK, 1023, 0, 1, 1, 0));

        for (int k = 0; k < rows.size(); k++) begin
            if (rows[k].is_cfg) begin
                wait_quiet();
                write_reg(rows[k].reg_idx, rows[k].reg_val);
                if (k + 1 == rows.size() || !rows[k + 1].is_cfg)
                    reg_ch.valid <= 1'b0;
            end else begin
                send_item(rows[k].op, rows[k].elapsed, rows[k].busy, rows[k].gate,
                          rows[k].queued, rows[k].draw, rows[k].known, rows[k].want);
                n_directed++;
            end
        end

        // Random phases over a spread of register settings
        program_regs(15, 1023, 7, 264, 52);
        run_phase(PHASE_ITEMS, 3, 60);
        program_regs(0, 0, 0, 0, 1);
        run_phase(PHASE_ITEMS, 10, 60);
        program_regs(1023, 1023, 15, 1023, 255);
        run_phase(PHASE_ITEMS, 50, 95);

        program_regs(3, 63, 3, 34, 9);
        set_pace(PACE_TX_GAPPY);
        run_phase(PHASE_ITEMS, 3, 60);
        // zero slot time with the largest retry limit, so the incremented retry count can hit 16
        program_regs(7, 255, 15, 0, 0);
        run_phase(PHASE_ITEMS, 50, 95);
        program_regs(63, 7, 1, 100, 20);
        run_phase(PHASE_ITEMS, 5, 50);

        program_regs(31, 1023, 5, 16, 1);
        set_pace(PACE_FULL);
        run_phase(PHASE_ITEMS, 3, 60);
        program_regs(1, 15, 2, 1023, 200);
        run_phase(PHASE_ITEMS, 5, 70);
        // arbitrary values, windows not necessarily of the form 2^k-1
        program_regs($urandom_range(1023), $urandom_range(1023), $urandom_range(15),
                     $urandom_range(1023), $urandom_range(255));
        run_phase(PHASE_ITEMS, 10, 60);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (status_due.size() != 0) begin
            $error("%0d expected results never arrived", status_due.size());
            mismatches++;
        end
        $display("Run: %0d events (%0d from the directed table), %0d results checked,",
                 n_events, n_directed, n_checked);
        $display("     %0d frame drops, %0d expiries, %0d register writes, %0d mismatches",
                 n_drops, n_expiries, n_writes, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
